>>> src/stereo_bandpass_biquad_top_assert.svh
// assertion macros shared by the stereo bandpass biquad rtl
`ifndef STEREO_BANDPASS_BIQUAD_TOP_ASSERT_SVH
`define STEREO_BANDPASS_BIQUAD_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBQ_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SBQ_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sbq_pkg.sv
// shared types, widths and constants of the stereo bandpass biquad
package sbq_pkg;

	// channel state layout
	localparam int NUM_CHANNELS   = 2;
	localparam int ADDR_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// arithmetic widths
	localparam int COEF_FRAC_BITS = 30;
	localparam int GUARD_BITS     = 8;
	localparam int SAMPLE_W       = 24;
	localparam int COEF_W         = 32;
	localparam int YH_W           = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int DIFF_W         = SAMPLE_W + 1;
	localparam int P0_W           = COEF_W + DIFF_W;
	localparam int P1_W           = COEF_W + YH_W;
	localparam int ACC_W          = P1_W + 3;
	localparam int OUT_W          = YH_W + 1;

	// rounding offsets and saturation limits
	localparam logic signed [ACC_W-1:0] ACC_HALF =
		ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] YH_MAX_ACC =
		ACC_W'({1'b0, {(YH_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] YH_MIN_ACC = -YH_MAX_ACC - ACC_W'(1);
	localparam logic signed [YH_W-1:0] YH_MAX = {1'b0, {(YH_W-1){1'b1}}};
	localparam logic signed [YH_W-1:0] YH_MIN = {1'b1, {(YH_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_RND = OUT_W'(1) << (GUARD_BITS - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX_W =
		OUT_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
	localparam logic signed [OUT_W-1:0] OUT_MIN_W = -OUT_MAX_W - OUT_W'(1);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEREO_MODE = 3'd0,
		REG_B0_LEFT     = 3'd1,
		REG_A1_LEFT     = 3'd2,
		REG_A2_LEFT     = 3'd3,
		REG_B0_RIGHT    = 3'd4,
		REG_A1_RIGHT    = 3'd5,
		REG_A2_RIGHT    = 3'd6
	} reg_idx_t;

	// one coefficient set, b2 is the negation of b0
	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	// per-channel history entry
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [YH_W-1:0]     y1;
		logic signed [YH_W-1:0]     y2;
	} hist_t;

	// stage load enables from the pipeline control
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} sbq_ctrl_t;

	// channel tag to history address, out-of-range tags use the last channel
	function automatic logic [ADDR_W-1:0] chan_to_addr(input logic chan_i);
		logic [ADDR_W-1:0] addr;
		if (int'(chan_i) < NUM_CHANNELS) begin
			addr = ADDR_W'(chan_i);
		end else begin
			addr = ADDR_W'(NUM_CHANNELS - 1);
		end
		return addr;
	endfunction

endpackage

>>> src/stereo_bandpass_biquad_top.sv
// top level of the two-channel bandpass biquad filter
//
// Usage:
// Input transactions carry a channel tag (chan) and a signed 24-bit sample
// (sample_in); each one yields exactly one output transaction with the
// filtered, rounded and saturated 24-bit sample (sample_out), in input order.
// Coefficients and stereo_mode are written through cfg_we/cfg_index/cfg_data
// while no transaction is in flight; unknown indexes are ignored.
// A transaction passes the history read register, the product register,
// the sum register and the output register, in that order. A channel takes a
// new transaction only after its previous one has left the accumulate stage
// and been written back to the per-channel history memory; until then in_stall
// holds it. Transactions of the other channel can be taken meanwhile.
// Reset clears the configuration, the pipeline and, through entry valid bits,
// the filter history of every channel.
// When the receiver raises out_stall the output register holds its sample;
// up to three more transactions are taken into the stages behind it, then
// in_stall rises until the output drains.
`include "stereo_bandpass_biquad_top_assert.svh"

module stereo_bandpass_biquad_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  chan,
	input  logic signed [sbq_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sbq_pkg::SAMPLE_W-1:0]   sample_out,
	input  logic                                  cfg_we,
	input  logic [sbq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sbq_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic                                 stereo_mode_q;
	sbq_pkg::coef_set_t                   coef_left_q;
	sbq_pkg::coef_set_t                   coef_right_q;

	logic                                 v1_q;
	logic                                 v2_q;
	logic                                 v3_q;
	logic                                 out_valid_q;
	logic                                 en_o;
	logic                                 en3;
	logic                                 en2;
	logic                                 en1;
	logic                                 hazard;
	logic                                 accept;
	logic [sbq_pkg::ADDR_W-1:0]           addr_in;

	logic                                 chan_s1;
	logic [sbq_pkg::ADDR_W-1:0]           addr_s1;
	logic [sbq_pkg::ADDR_W-1:0]           addr_s2;
	logic signed [sbq_pkg::SAMPLE_W-1:0]  x_s1;
	sbq_pkg::coef_set_t                   coef_s1;

	sbq_pkg::hist_t                       hist_s1;
	sbq_pkg::hist_t                       hist_new;
	logic                                 mem_wr_en;
	sbq_pkg::sbq_ctrl_t                   ctrl;
	logic signed [sbq_pkg::YH_W-1:0]      yh_s3;

	logic signed [sbq_pkg::OUT_W-1:0]     rnd_s3;
	logic signed [sbq_pkg::OUT_W-1:0]     shf_s3;
	logic signed [sbq_pkg::SAMPLE_W-1:0]  sat_s3;
	logic signed [sbq_pkg::SAMPLE_W-1:0]  sample_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
			coef_left_q   <= '0;
			coef_right_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sbq_pkg::REG_STEREO_MODE: stereo_mode_q   <= cfg_data[0];
				sbq_pkg::REG_B0_LEFT:     coef_left_q.b0  <= $signed(cfg_data);
				sbq_pkg::REG_A1_LEFT:     coef_left_q.a1  <= $signed(cfg_data);
				sbq_pkg::REG_A2_LEFT:     coef_left_q.a2  <= $signed(cfg_data);
				sbq_pkg::REG_B0_RIGHT:    coef_right_q.b0 <= $signed(cfg_data);
				sbq_pkg::REG_A1_RIGHT:    coef_right_q.a1 <= $signed(cfg_data);
				sbq_pkg::REG_A2_RIGHT:    coef_right_q.a2 <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage advance: a stage loads when empty or when the one ahead moves
	assign en_o    = !out_valid_q || !out_stall;
	assign en3     = !v3_q || en_o;
	assign en2     = !v2_q || en3;
	assign en1     = !v1_q || en2;
	assign addr_in = sbq_pkg::chan_to_addr(chan);

	// interlock: history of this channel not yet written back
	assign hazard   = (v1_q && (addr_s1 == addr_in)) || (v2_q && (addr_s2 == addr_in));
	assign in_stall = !en1 || hazard;
	assign accept   = in_valid && !in_stall;

	assign ctrl.load_s2 = en2;
	assign ctrl.load_s3 = en3;
	assign mem_wr_en    = v2_q && en3;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en_o) begin
				out_valid_q <= v3_q;
			end
		end
	end

	// transaction payload through the stages
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1 <= chan;
			addr_s1 <= addr_in;
			x_s1    <= sample_in;
		end
		if (en2) begin
			addr_s2 <= addr_s1;
		end
	end

	// right set only for channel 1 in stereo mode
	assign coef_s1 = (stereo_mode_q && (chan_s1 == 1'b1)) ? coef_right_q : coef_left_q;

	sbq_state_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (addr_in),
		.rd_data_q (hist_s1),
		.wr_en     (mem_wr_en),
		.wr_addr   (addr_s2),
		.wr_data   (hist_new)
	);

	sbq_filter_core u_core (
		.clk      (clk),
		.ctrl     (ctrl),
		.x_s1     (x_s1),
		.coef_s1  (coef_s1),
		.hist_s1  (hist_s1),
		.hist_new (hist_new),
		.yh_s3    (yh_s3)
	);

	// drop guard bits with round half up, saturate to 24 bits
	always_comb begin
		rnd_s3 = sbq_pkg::OUT_W'(yh_s3) + sbq_pkg::OUT_RND;
		shf_s3 = rnd_s3 >>> sbq_pkg::GUARD_BITS;
		if (shf_s3 > sbq_pkg::OUT_MAX_W) begin
			sat_s3 = sbq_pkg::SAMPLE_MAX;
		end else if (shf_s3 < sbq_pkg::OUT_MIN_W) begin
			sat_s3 = sbq_pkg::SAMPLE_MIN;
		end else begin
			sat_s3 = $signed(shf_s3[sbq_pkg::SAMPLE_W-1:0]);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_o) begin
			sample_out_q <= sat_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// checks
	`SBQ_ASSERT_IMP(a_no_same_chan_s1_s2, clk, arst_n, v1_q && v2_q, addr_s1 != addr_s2, "same channel in product and sum stages")
	`SBQ_ASSERT_IMP(a_no_rd_wr_collision, clk, arst_n, mem_wr_en && accept, addr_s2 != addr_in, "history read collides with write-back")
	`SBQ_ASSERT_IMP(a_hazard_holds_input, clk, arst_n, in_valid && v1_q && (addr_s1 == addr_in), in_stall, "pending channel not held off")
	`SBQ_ASSERT_NXT(a_s3_reaches_output, clk, arst_n, v3_q && en_o, out_valid_q, "stage 3 transaction lost")

endmodule

>>> src/sbq_state_mem.sv
// per-channel history memory with registered read and reset valid bits
module sbq_state_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [sbq_pkg::ADDR_W-1:0]   rd_addr,
	output sbq_pkg::hist_t               rd_data_q,
	input  logic                         wr_en,
	input  logic [sbq_pkg::ADDR_W-1:0]   wr_addr,
	input  sbq_pkg::hist_t               wr_data
);

	sbq_pkg::hist_t                    mem_q [sbq_pkg::NUM_CHANNELS];
	logic [sbq_pkg::NUM_CHANNELS-1:0]  valid_q;

	// entry valid bits, cleared at reset so untouched channels read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (valid_q[rd_addr]) begin
				rd_data_q <= mem_q[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

endmodule

>>> src/sbq_filter_core.sv
// biquad datapath: product stage, accumulate and saturate stage
module sbq_filter_core (
	input  logic                                clk,
	input  sbq_pkg::sbq_ctrl_t                  ctrl,
	input  logic signed [sbq_pkg::SAMPLE_W-1:0] x_s1,
	input  sbq_pkg::coef_set_t                  coef_s1,
	input  sbq_pkg::hist_t                      hist_s1,
	output sbq_pkg::hist_t                      hist_new,
	output logic signed [sbq_pkg::YH_W-1:0]     yh_s3
);

	logic signed [sbq_pkg::COEF_W-1:0]   b0_s1;
	logic signed [sbq_pkg::COEF_W-1:0]   a1_s1;
	logic signed [sbq_pkg::COEF_W-1:0]   a2_s1;
	logic signed [sbq_pkg::SAMPLE_W-1:0] x2_s1;
	logic signed [sbq_pkg::YH_W-1:0]     y1_s1;
	logic signed [sbq_pkg::YH_W-1:0]     y2_s1;
	logic signed [sbq_pkg::DIFF_W-1:0]   diff_s1;
	logic signed [sbq_pkg::P0_W-1:0]     p0_s1;
	logic signed [sbq_pkg::P1_W-1:0]     p1_s1;
	logic signed [sbq_pkg::P1_W-1:0]     p2_s1;

	logic signed [sbq_pkg::P0_W-1:0]     p0_s2;
	logic signed [sbq_pkg::P1_W-1:0]     p1_s2;
	logic signed [sbq_pkg::P1_W-1:0]     p2_s2;
	logic signed [sbq_pkg::SAMPLE_W-1:0] x_s2;
	logic signed [sbq_pkg::SAMPLE_W-1:0] x1_s2;
	logic signed [sbq_pkg::YH_W-1:0]     y1_s2;
	logic signed [sbq_pkg::ACC_W-1:0]    acc_s2;
	logic signed [sbq_pkg::ACC_W-1:0]    quo_s2;
	logic signed [sbq_pkg::YH_W-1:0]     yh_s2;

	// unpack operands
	assign b0_s1 = coef_s1.b0;
	assign a1_s1 = coef_s1.a1;
	assign a2_s1 = coef_s1.a2;
	assign x2_s1 = hist_s1.x2;
	assign y1_s1 = hist_s1.y1;
	assign y2_s1 = hist_s1.y2;

	// stage 1: three independent products, b0 shared by x and -x2
	assign diff_s1 = sbq_pkg::DIFF_W'(x_s1) - sbq_pkg::DIFF_W'(x2_s1);
	assign p0_s1   = sbq_pkg::P0_W'(b0_s1) * sbq_pkg::P0_W'(diff_s1);
	assign p1_s1   = sbq_pkg::P1_W'(a1_s1) * sbq_pkg::P1_W'(y1_s1);
	assign p2_s1   = sbq_pkg::P1_W'(a2_s1) * sbq_pkg::P1_W'(y2_s1);

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			p0_s2 <= p0_s1;
			p1_s2 <= p1_s1;
			p2_s2 <= p2_s1;
			x_s2  <= x_s1;
			x1_s2 <= hist_s1.x1;
			y1_s2 <= y1_s1;
		end
	end

	// stage 2: exact sum, round half up to guard precision, saturate
	always_comb begin
		acc_s2 = (sbq_pkg::ACC_W'(p0_s2) <<< sbq_pkg::GUARD_BITS)
			- sbq_pkg::ACC_W'(p1_s2) - sbq_pkg::ACC_W'(p2_s2) + sbq_pkg::ACC_HALF;
		quo_s2 = acc_s2 >>> sbq_pkg::COEF_FRAC_BITS;
		if (quo_s2 > sbq_pkg::YH_MAX_ACC) begin
			yh_s2 = sbq_pkg::YH_MAX;
		end else if (quo_s2 < sbq_pkg::YH_MIN_ACC) begin
			yh_s2 = sbq_pkg::YH_MIN;
		end else begin
			yh_s2 = $signed(quo_s2[sbq_pkg::YH_W-1:0]);
		end
	end

	// updated history for write-back
	always_comb begin
		hist_new.x1 = x_s2;
		hist_new.x2 = x1_s2;
		hist_new.y1 = yh_s2;
		hist_new.y2 = y1_s2;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			yh_s3 <= yh_s2;
		end
	end

endmodule

>>> tb/tb_stereo_bandpass_biquad_top.sv
// self-checking testbench for the stereo bandpass biquad top level
module tb_stereo_bandpass_biquad_top;
	import sbq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 123;

	// index with no register behind it, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_IDX_UNMAPPED = 3'd7;

	// notable Q2.30 coefficient values
	localparam logic signed [COEF_W-1:0] Q_ONE       = 32'sh4000_0000;
	localparam logic signed [COEF_W-1:0] Q_MINUS_ONE = 32'shC000_0000;
	localparam logic signed [COEF_W-1:0] COEF_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN    = 32'sh8000_0000;

	typedef enum int {CHAN_RANDOM, CHAN_ALTERNATE, CHAN_RUNS} chan_pattern_t;

	// filter predictor plus queue of expected output samples
	class biquad_scoreboard;
		bit stereo_on;
		coef_set_t left_set;
		coef_set_t right_set;
		hist_t hist[NUM_CHANNELS];
		logic signed [SAMPLE_W-1:0] expected_q[$];
		int n_errors;
		int n_samples;
		int n_results;
		int n_saturated;

		function new();
			stereo_on = 1'b0;
			left_set = '0;
			right_set = '0;
			foreach (hist[i]) hist[i] = '0;
			n_errors = 0;
			n_samples = 0;
			n_results = 0;
			n_saturated = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// mirror of a register write
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_STEREO_MODE: stereo_on = data[0];
				REG_B0_LEFT:     left_set.b0 = data;
				REG_A1_LEFT:     left_set.a1 = data;
				REG_A2_LEFT:     left_set.a2 = data;
				REG_B0_RIGHT:    right_set.b0 = data;
				REG_A1_RIGHT:    right_set.a1 = data;
				REG_A2_RIGHT:    right_set.a2 = data;
				default: ;
			endcase
		endfunction

		// accepted input transaction: run one filter step, queue the output
		function void note_sample(logic ch, logic signed [SAMPLE_W-1:0] x);
			coef_set_t cs;
			int ci;
			logic signed [79:0] acc;
			logic signed [79:0] b0w;
			logic signed [79:0] a1w;
			logic signed [79:0] a2w;
			logic signed [79:0] dx;
			logic signed [79:0] y1w;
			logic signed [79:0] y2w;
			logic signed [79:0] yw;
			logic signed [YH_W-1:0] yh;
			logic signed [39:0] ow;
			logic signed [SAMPLE_W-1:0] y_out;
			ci = (int'(ch) < NUM_CHANNELS) ? int'(ch) : NUM_CHANNELS - 1;
			cs = (stereo_on && ch) ? right_set : left_set;
			b0w = 80'(cs.b0);
			a1w = 80'(cs.a1);
			a2w = 80'(cs.a2);
			dx = 80'(x);
			dx = dx - 80'(hist[ci].x2);
			y1w = 80'(hist[ci].y1);
			y2w = 80'(hist[ci].y2);
			// exact sum, half an lsb added, then floor back to 8 guard bits
			acc = ((b0w * dx) <<< GUARD_BITS) - a1w * y1w - a2w * y2w
				+ (80'sd1 <<< (COEF_FRAC_BITS - 1));
			yw = acc >>> COEF_FRAC_BITS;
			if (yw > 80'sd2147483647) begin
				yh = YH_MAX;
			end else if (yw < -80'sd2147483648) begin
				yh = YH_MIN;
			end else begin
				yh = yw[YH_W-1:0];
			end
			// drop guard bits with rounding, clamp to 24 bits
			ow = 40'(yh);
			ow = (ow + (40'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
			if (ow > 40'sd8388607) begin
				y_out = SAMPLE_MAX;
			end else if (ow < -40'sd8388608) begin
				y_out = SAMPLE_MIN;
			end else begin
				y_out = ow[SAMPLE_W-1:0];
			end
			if (y_out == SAMPLE_MAX || y_out == SAMPLE_MIN) n_saturated++;
			hist[ci].x2 = hist[ci].x1;
			hist[ci].x1 = x;
			hist[ci].y2 = hist[ci].y1;
			hist[ci].y1 = yh;
			expected_q.push_back(y_out);
			n_samples++;
		endfunction

		// accepted output transaction against the oldest expectation
		function void check_sample(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			n_results++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected sample_out %0d, nothing pending", $time, got);
				n_errors++;
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, got %0d",
						$time, want, got);
					n_errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic chan = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	biquad_scoreboard sb = new();
	bit quiet_sender = 1'b0;
	int n_settings = 0;
	int n_stereo_settings = 0;
	int idle_cycles = 0;

	stereo_bandpass_biquad_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan       (chan),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// gap length: mostly short, a few long
	function automatic int pick_gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// input sample: rails, full-range noise or scaled-down noise
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] s;
		int r;
		r = $urandom_range(0, 99);
		s = SAMPLE_W'($urandom);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: s = SAMPLE_MAX;
				1: s = SAMPLE_MIN;
				2: s = '0;
				default: s = '1;
			endcase
		end else if (r >= 45) begin
			s = s >>> $urandom_range(1, 20);
		end
		return s;
	endfunction

	// stable biquad: |a2| < 0.95, |a1| inside the stability triangle
	function automatic coef_set_t stable_set();
		coef_set_t cs;
		int unsigned bound;
		cs.b0 = $urandom_range(0, 32'h1000_0000);
		if ($urandom_range(0, 1)) cs.b0 = -cs.b0;
		cs.a2 = $urandom_range(0, 1020054732);
		bound = 32'h4000_0000 + cs.a2 - 32'h0080_0000;
		cs.a1 = $urandom_range(0, 2 * bound) - bound;
		return cs;
	endfunction

	function automatic logic signed [COEF_W-1:0] extreme_coef();
		case ($urandom_range(0, 4))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return Q_ONE;
			3: return Q_MINUS_ONE;
			default: return '0;
		endcase
	endfunction

	function automatic coef_set_t extreme_set();
		coef_set_t cs;
		cs.b0 = extreme_coef();
		cs.a1 = extreme_coef();
		cs.a2 = extreme_coef();
		return cs;
	endfunction

	// one input transaction, then an optional idle gap
	task automatic send_sample(logic ch, logic signed [SAMPLE_W-1:0] s);
		int gap;
		in_valid <= 1'b1;
		chan <= ch;
		sample_in <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		gap = (quiet_sender || $urandom_range(0, 1)) ? 0 : pick_gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every pending output
	task automatic drain_outputs();
		in_valid <= 1'b0;
		// let the monitor note a transaction accepted at this very edge
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// full register setup, only while the filter is idle
	task automatic program_filter(logic st, coef_set_t l, coef_set_t r, bit poke);
		logic [CFG_DATA_W-1:0] mode_word;
		mode_word = $urandom;
		mode_word[0] = st;
		write_reg(REG_STEREO_MODE, mode_word);
		write_reg(REG_B0_LEFT, l.b0);
		write_reg(REG_A1_LEFT, l.a1);
		write_reg(REG_A2_LEFT, l.a2);
		write_reg(REG_B0_RIGHT, r.b0);
		write_reg(REG_A1_RIGHT, r.a1);
		write_reg(REG_A2_RIGHT, r.a2);
		if (poke) write_reg(REG_IDX_UNMAPPED, $urandom);
		cfg_we <= 1'b0;
		n_settings++;
		if (st) n_stereo_settings++;
	endtask

	// random samples with a per-phase channel pattern and idling style
	task automatic run_random_phase(int n);
		chan_pattern_t pat;
		logic ch;
		pat = chan_pattern_t'($urandom_range(0, 2));
		quiet_sender = ($urandom_range(0, 3) == 0);
		ch = 1'($urandom_range(0, 1));
		for (int k = 0; k < n; k++) begin
			case (pat)
				CHAN_RANDOM:    ch = 1'($urandom_range(0, 1));
				CHAN_ALTERNATE: ch = ~ch;
				default:        if ($urandom_range(0, 4) == 0) ch = ~ch;
			endcase
			send_sample(ch, pick_sample());
		end
		quiet_sender = 1'b0;
	endtask

	// transaction monitors
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_sample(chan, sample_in);
			if (out_valid && !out_stall) sb.check_sample(sample_out);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d outputs pending",
				$time, idle_cycles, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output back-pressure: free-running stretches and random stalls
	initial begin : stall_gen
		int r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			out_stall <= 1'b0;
			if (r < 25) begin
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b1;
				repeat (pick_gap_len()) @(posedge clk);
			end
		end
	end

	// main sequence
	initial begin : stimulus
		coef_set_t l;
		coef_set_t r;
		int kind;
		logic signed [SAMPLE_W-1:0] rail_seq[5];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients are zero after reset, so the output is silent
		send_sample(1'b0, SAMPLE_MAX);
		send_sample(1'b1, SAMPLE_MIN);
		send_sample(1'b0, '0);
		send_sample(1'b1, '1);
		drain_outputs();

		// unity b0 gives x minus x two back, pushed into both rails;
		// mono mode keeps channel 1 on the left set despite the wild right set
		program_filter(1'b0, coef_set_t'{Q_ONE, 32'sd0, 32'sd0},
			coef_set_t'{COEF_MIN, COEF_MAX, COEF_MIN}, 1'b0);
		rail_seq = '{SAMPLE_MIN, '0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN};
		foreach (rail_seq[k]) begin
			send_sample(1'b0, rail_seq[k]);
			send_sample(1'b1, rail_seq[k]);
		end
		drain_outputs();

		// stereo with extreme coefficients, plus a write to an unmapped index
		program_filter(1'b1, coef_set_t'{Q_MINUS_ONE, COEF_MIN, COEF_MAX},
			coef_set_t'{COEF_MIN, COEF_MAX, COEF_MIN}, 1'b1);
		send_sample(1'b1, SAMPLE_MAX);
		send_sample(1'b1, SAMPLE_MIN);
		send_sample(1'b0, 24'sd1);
		send_sample(1'b1, SAMPLE_MAX);
		send_sample(1'b0, -24'sd1);
		send_sample(1'b1, '0);
		send_sample(1'b1, -24'sd1);

		// random phases, mostly stable filters
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				l = stable_set();
				r = stable_set();
			end else if (kind < 8) begin
				l = {$urandom, $urandom, $urandom};
				r = {$urandom, $urandom, $urandom};
			end else begin
				l = extreme_set();
				r = extreme_set();
			end
			drain_outputs();
			program_filter(1'($urandom_range(0, 1)), l, r, $urandom_range(0, 3) == 0);
			run_random_phase(PHASE_ITEMS);
		end

		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Filtered %0d samples under %0d coefficient setups (%0d stereo), %0d checked",
			sb.n_samples, n_settings, n_stereo_settings, sb.n_results);
		$display("%0d outputs at a saturation rail, %0d mismatches",
			sb.n_saturated, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
